[src/tekd_pkg.sv]
package tekd_pkg;

   typedef enum logic [2:0] {
      PH_IDLE  = 3'd0,
      PH_ESC   = 3'd1,
      PH_INTRO = 3'd2,
      PH_SKIP  = 3'd3,
      PH_DIGIT = 3'd4,
      PH_SEMI  = 3'd5,
      PH_MOD   = 3'd6
   } phase_type;

   localparam logic [4:0] KC_PLAIN = 5'd0;
   localparam logic [4:0] KC_ESC   = 5'd1;
   localparam logic [4:0] KC_DEL   = 5'd2;
   localparam logic [4:0] KC_PGUP  = 5'd3;
   localparam logic [4:0] KC_PGDN  = 5'd4;
   localparam logic [4:0] KC_HOME  = 5'd5;
   localparam logic [4:0] KC_END   = 5'd6;
   localparam logic [4:0] KC_ARROW = 5'd7;
   localparam logic [4:0] KC_LAST  = 5'd22;

   localparam logic [7:0] CH_ESC     = 8'h1B;
   localparam logic [7:0] CH_BRACKET = 8'h5B;
   localparam logic [7:0] CH_O       = 8'h4F;
   localparam logic [7:0] CH_TILDE   = 8'h7E;
   localparam logic [7:0] CH_SEMI    = 8'h3B;
   localparam logic [7:0] CH_2       = 8'h32;
   localparam logic [7:0] CH_3       = 8'h33;
   localparam logic [7:0] CH_5       = 8'h35;
   localparam logic [7:0] CH_6       = 8'h36;
   localparam logic [7:0] CH_0       = 8'h30;
   localparam logic [7:0] CH_9       = 8'h39;
   localparam logic [7:0] CH_A       = 8'h41;
   localparam logic [7:0] CH_D       = 8'h44;
   localparam logic [7:0] CH_H       = 8'h48;
   localparam logic [7:0] CH_F       = 8'h46;

   localparam logic [1:0] MOD_SHIFT      = 2'd1;
   localparam logic [1:0] MOD_CTRL       = 2'd2;
   localparam logic [1:0] MOD_CTRL_SHIFT = 2'd3;

   typedef struct packed {
      phase_type  phase;
      logic       intro_is_bracket;
      logic [7:0] held_digit;
      logic [1:0] arrow_modifier;
   } parse_state_type;

   typedef struct packed {
      logic       emit;
      logic [4:0] key_code;
      logic [7:0] char_value;
   } key_result_type;

endpackage

[src/terminal_escape_key_decoder.sv]
// Decodes VT100/xterm keyboard input one request at a time: each request carries a
// received byte or a read-timeout event, and yields zero or one key result (plain
// character, ESC, delete, page up/down, home, end, or an arrow with its modifier).
// A new request is accepted every clock cycle unless the input side is stalled; a
// request is held in an input register, decoded by the one-step parser state
// update, and its key lands in the result register. The result register stalls
// the input side only while a result waits and the result channel is not ready.
// A timeout in mid-sequence, or any unrecognized sequence, gives ESC and drops
// the bytes read so far; a timeout while idle gives nothing.
module terminal_escape_key_decoder (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_rx_byte,
   input  logic       req_timeout,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [4:0] rsp_key_code,
   output logic [7:0] rsp_char_value
);
   import tekd_pkg::*;

   logic            in_valid_ff;
   logic [7:0]      in_byte_ff;
   logic            in_timeout_ff;
   parse_state_type state_ff;
   parse_state_type state_in;
   key_result_type  step_result;
   logic            out_valid_ff;
   logic [4:0]      out_code_ff;
   logic [7:0]      out_char_ff;
   logic            advance;

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   tekd_step u_step (
      .cur_state  (state_ff),
      .rx_byte    (in_byte_ff),
      .timeout    (in_timeout_ff),
      .next_state (state_in),
      .result     (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
         state_ff       <= '{phase: PH_IDLE, intro_is_bracket: 1'b0,
                             held_digit: 8'd0, arrow_modifier: 2'd0};
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            state_ff     <= state_in;
            out_valid_ff <= step_result.emit;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff    <= req_rx_byte;
         in_timeout_ff <= req_timeout;
      end
      if (advance && step_result.emit) begin
         out_code_ff <= step_result.key_code;
         out_char_ff <= step_result.char_value;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_key_code   = out_code_ff;
   assign rsp_char_value = out_char_ff;

endmodule

[src/tekd_step.sv]
module tekd_step (
   input  tekd_pkg::parse_state_type cur_state,
   input  logic [7:0]                rx_byte,
   input  logic                      timeout,
   output tekd_pkg::parse_state_type next_state,
   output tekd_pkg::key_result_type  result
);
   import tekd_pkg::*;

   logic       is_digit;
   logic       is_arrow;
   logic [1:0] arrow_dir;
   logic       is_mod_digit;
   logic [1:0] mod_code;

   assign is_digit  = (rx_byte >= CH_0) && (rx_byte <= CH_9);
   assign is_arrow  = (rx_byte >= CH_A) && (rx_byte <= CH_D);
   assign arrow_dir = rx_byte[1:0] - CH_A[1:0];

   always_comb begin
      is_mod_digit = 1'b1;
      mod_code     = MOD_SHIFT;
      unique case (rx_byte)
         CH_2: mod_code = MOD_SHIFT;
         CH_5: mod_code = MOD_CTRL;
         CH_6: mod_code = MOD_CTRL_SHIFT;
         default: is_mod_digit = 1'b0;
      endcase
   end

   // Next state. Every emitted key returns the parser to idle.
   always_comb begin
      next_state = cur_state;
      unique case (cur_state.phase)
         PH_ESC: begin
            if (timeout) begin
               next_state.phase = PH_IDLE;
            end else if (rx_byte == CH_BRACKET || rx_byte == CH_O) begin
               next_state.phase            = PH_INTRO;
               next_state.intro_is_bracket = (rx_byte == CH_BRACKET);
            end else begin
               next_state.phase = PH_SKIP;
            end
         end
         PH_SKIP: next_state.phase = PH_IDLE;
         PH_INTRO: begin
            if (!timeout && cur_state.intro_is_bracket && is_digit) begin
               next_state.phase      = PH_DIGIT;
               next_state.held_digit = rx_byte;
            end else begin
               next_state.phase = PH_IDLE;
            end
         end
         PH_DIGIT: begin
            next_state.phase = (!timeout && rx_byte == CH_SEMI) ? PH_SEMI : PH_IDLE;
         end
         PH_SEMI: begin
            if (!timeout && is_mod_digit) begin
               next_state.phase          = PH_MOD;
               next_state.arrow_modifier = mod_code;
            end else begin
               next_state.phase = PH_IDLE;
            end
         end
         PH_MOD: next_state.phase = PH_IDLE;
         default: begin
            // Idle, and the unused phase code that behaves as idle.
            next_state.phase = (!timeout && rx_byte == CH_ESC) ? PH_ESC : PH_IDLE;
         end
      endcase
   end

   // Result for this request.
   always_comb begin
      result.emit       = 1'b1;
      result.key_code   = KC_ESC;
      result.char_value = 8'd0;
      unique case (cur_state.phase)
         PH_ESC: result.emit = timeout;
         PH_SKIP: result.key_code = KC_ESC;
         PH_INTRO: begin
            if (timeout) begin
               result.key_code = KC_ESC;
            end else if (cur_state.intro_is_bracket && is_digit) begin
               result.emit = 1'b0;
            end else if (cur_state.intro_is_bracket && is_arrow) begin
               result.key_code = KC_ARROW + {3'd0, arrow_dir};
            end else if (rx_byte == CH_H) begin
               result.key_code = KC_HOME;
            end else if (rx_byte == CH_F) begin
               result.key_code = KC_END;
            end
         end
         PH_DIGIT: begin
            if (!timeout && rx_byte == CH_TILDE) begin
               if (cur_state.held_digit == CH_3) begin
                  result.key_code = KC_DEL;
               end else if (cur_state.held_digit == CH_5) begin
                  result.key_code = KC_PGUP;
               end else if (cur_state.held_digit == CH_6) begin
                  result.key_code = KC_PGDN;
               end
            end else if (!timeout && rx_byte == CH_SEMI) begin
               result.emit = 1'b0;
            end
         end
         PH_SEMI: result.emit = timeout || !is_mod_digit;
         PH_MOD: begin
            if (!timeout && is_arrow) begin
               result.key_code = KC_ARROW + {1'b0, cur_state.arrow_modifier, arrow_dir};
            end
         end
         default: begin
            result.emit       = !timeout && rx_byte != CH_ESC;
            result.key_code   = KC_PLAIN;
            result.char_value = rx_byte;
         end
      endcase
   end

endmodule

[src/tekd_checker.sv]
module tekd_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic [7:0] req_rx_byte,
   input logic       req_timeout,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [4:0] rsp_key_code,
   input logic [7:0] rsp_char_value
);
   import tekd_pkg::*;

   // A request that waits keeps its contents.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_rx_byte)
                                 && $stable(req_timeout))
      else $error("stalled request changed");

   // A result that is not taken keeps its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_key_code)
                                 && $stable(rsp_char_value))
      else $error("stalled result changed");

   // Only plain characters carry a byte value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_key_code != KC_PLAIN |-> rsp_char_value == 8'd0)
      else $error("non-character key carries a byte value");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_key_code <= KC_LAST)
      else $error("key code out of range");

   // Reset leaves no result pending.
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind terminal_escape_key_decoder tekd_checker u_tekd_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .req_rx_byte    (req_rx_byte),
   .req_timeout    (req_timeout),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_key_code   (rsp_key_code),
   .rsp_char_value (rsp_char_value)
);
